>>> src/scbr_pkg.sv
// ----------------------------------------------------------------------------
// scbr_pkg
// Types and constants for the size-class buffer recycler.
// ----------------------------------------------------------------------------
package scbr_pkg;

    localparam int NUM_CLASSES     = 32;
    localparam int NUM_DESCRIPTORS = 1024;
    localparam int POOL_ADDR_BITS  = 24;
    localparam int HANDLE_W        = 10;
    localparam int CLASS_W         = 5;
    localparam logic [15:0] IMMORTAL = 16'hFFFF;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_KEEP   = 2'd2;
    localparam logic [1:0] MODE_REALLOC = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EXHAUST = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] length;
        logic [9:0]  handle;
    } cmd_t;

    typedef struct packed {
        logic [9:0]  result_handle;
        logic [23:0] data_address;
        logic [16:0] usable_bytes;
        logic [4:0]  size_class;
        logic        released;
        logic        copy_needed;
        logic [1:0]  status;
        logic [24:0] pool_bytes_used;
    } rsp_t;

    // descriptor word: count, class, base
    typedef struct packed {
        logic [15:0] count;
        logic [4:0]  cls;
        logic [23:0] base;
    } desc_t;

    function automatic logic [5:0] class_of(input logic [15:0] len);
        logic [16:0] l;
        logic [5:0]  q;
        l = ({1'b0, len} + 17'd15) >> 4;
        q = 6'd4;
        for (int i = 12; i >= 0; i--) begin
            if (l[i] && q == 6'd4)
            begin
                q = 6'(i + 5);
            end
        end
        return q;
    endfunction

endpackage

>>> src/scbr_ram.sv
// ----------------------------------------------------------------------------
// scbr_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module scbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> src/size_class_buffer_recycler_top.sv
// ----------------------------------------------------------------------------
// size_class_buffer_recycler_top
// Power-of-two segregated free-list allocator with reference counts.
// ----------------------------------------------------------------------------
// Usage: drive a command word on cmd with start high while busy is low; the
// word is taken at that edge and busy rises. One result word appears on rsp
// with done high for exactly one cycle; the receiver cannot stall it.
// Each word is handled by the sequencer stepping through the single-port
// descriptor and link memories (read, then write, one access a cycle); a
// reallocate that moves reads and writes the descriptors of both buffers.
// List heads (32) and valid bits live in flip-flops. Reference counts are
// stored in the descriptor memory; descriptors at or above the used count
// are never read, so no clearing pass is needed after reset.
// Reset empties all lists and clears the used counts; busy is low after it.
// ----------------------------------------------------------------------------
module size_class_buffer_recycler_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  scbr_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done,
    output scbr_pkg::rsp_t    rsp
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_RD     = 9'b000000010,
        S_CHK    = 9'b000000100,
        S_ALLOC  = 9'b000001000,
        S_POPW   = 9'b000010000,
        S_NEWR   = 9'b000100000,
        S_OLDR   = 9'b001000000,
        S_OLDW   = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    scbr_pkg::cmd_t cmd_reg;
    scbr_pkg::rsp_t rsp_reg, rsp_next;
    logic done_reg;
    logic [10:0] used_reg, used_next;
    logic [24:0] top_reg, top_next;
    logic [9:0]  head_idx_reg [scbr_pkg::NUM_CLASSES];
    logic [scbr_pkg::NUM_CLASSES-1:0] head_vld_reg;
    logic [5:0]  q_reg;
    logic [9:0]  new_reg;
    logic        realloc_reg;
    scbr_pkg::desc_t old_reg;

    logic            d_we, l_we;
    logic [9:0]      d_addr, l_addr;
    scbr_pkg::desc_t d_wdata, d_rdata;
    logic [10:0]     l_wdata, l_rdata;

    scbr_ram #(.WIDTH(45), .DEPTH(scbr_pkg::NUM_DESCRIPTORS)) u_desc (
        .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata));
    scbr_ram #(.WIDTH(11), .DEPTH(scbr_pkg::NUM_DESCRIPTORS)) u_link (
        .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata));

    logic [5:0]  q_calc;
    logic [4:0]  qi;
    logic [25:0] sz, fit;
    logic [16:0] usable;
    logic        hd_ok;
    logic        push_now;
    logic [4:0]  push_q;
    logic        pop_now;
    logic [16:0] old_siz;

    assign q_calc = scbr_pkg::class_of(cmd_reg.length);
    assign qi     = q_reg[4:0];
    assign sz     = 26'd1 << q_reg;
    assign fit    = {1'b0, top_reg} + sz;
    assign hd_ok  = q_reg < 6'(scbr_pkg::NUM_CLASSES) && head_vld_reg[qi];
    assign old_siz = 17'((18'd1 << d_rdata.cls) - 18'd16);

    always_comb
    begin
        state_next = state_reg;
        rsp_next   = rsp_reg;
        used_next  = used_reg;
        top_next   = top_reg;
        d_we = 1'b0; l_we = 1'b0;
        d_addr = cmd_reg.handle; l_addr = cmd_reg.handle;
        d_wdata = d_rdata; l_wdata = l_rdata;
        push_now = 1'b0; push_q = old_reg.cls;
        pop_now = 1'b0;
        usable = 17'((18'd1 << qi) - 18'd16);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                rsp_next = '0;
                if (cmd_reg.mode == scbr_pkg::MODE_ALLOC)
                begin
                    state_next = S_ALLOC;
                end
                else if ({1'b0, cmd_reg.handle} >= used_reg)
                begin
                    rsp_next.status = scbr_pkg::ST_BAD;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (d_rdata.count == 16'd0)
                begin
                    rsp_next.status = scbr_pkg::ST_BAD;
                    state_next = S_OUT;
                end
                else
                begin
                    rsp_next.result_handle = cmd_reg.handle;
                    rsp_next.data_address  = d_rdata.base + 24'd16;
                    rsp_next.usable_bytes  = old_siz;
                    rsp_next.size_class    = d_rdata.cls;
                    unique case (cmd_reg.mode)
                        scbr_pkg::MODE_KEEP:
                        begin
                            d_we = d_rdata.count != scbr_pkg::IMMORTAL;
                            d_wdata.count = d_rdata.count + 16'd1;
                            state_next = S_OUT;
                        end
                        scbr_pkg::MODE_FREE:
                        begin
                            state_next = S_OLDW;
                        end
                        default:
                        begin
                            if (cmd_reg.length <= old_siz[15:0] || old_siz[16])
                            begin
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_ALLOC;
                            end
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (hd_ok)
                begin
                    l_addr = head_idx_reg[qi];
                    state_next = S_POPW;
                end
                else if (q_reg >= 6'(scbr_pkg::NUM_CLASSES)
                         || used_reg >= 11'(scbr_pkg::NUM_DESCRIPTORS)
                         || fit > (26'd1 << scbr_pkg::POOL_ADDR_BITS))
                begin
                    rsp_next = '0;
                    rsp_next.status = scbr_pkg::ST_EXHAUST;
                    state_next = S_OUT;
                end
                else
                begin
                    d_we = 1'b1;
                    d_addr = used_reg[9:0];
                    d_wdata.count = 16'd1;
                    d_wdata.cls = qi;
                    d_wdata.base = top_reg[23:0];
                    rsp_next = '0;
                    rsp_next.result_handle = used_reg[9:0];
                    rsp_next.data_address = top_reg[23:0] + 24'd16;
                    rsp_next.usable_bytes = usable;
                    rsp_next.size_class = qi;
                    rsp_next.copy_needed = realloc_reg;
                    used_next = used_reg + 11'd1;
                    top_next = fit[24:0];
                    state_next = realloc_reg ? S_OLDR : S_OUT;
                end
            end
            S_POPW:
            begin
                pop_now = 1'b1;
                d_addr = head_idx_reg[qi];
                state_next = S_NEWR;
            end
            S_NEWR:
            begin
                d_we = 1'b1;
                d_addr = new_reg;
                d_wdata.count = 16'd1;
                d_wdata.cls = qi;
                rsp_next = '0;
                rsp_next.result_handle = new_reg;
                rsp_next.data_address = d_rdata.base + 24'd16;
                rsp_next.usable_bytes = usable;
                rsp_next.size_class = qi;
                rsp_next.copy_needed = realloc_reg;
                state_next = realloc_reg ? S_OLDR : S_OUT;
            end
            S_OLDR:
            begin
                state_next = S_OLDW;
            end
            S_OLDW:
            begin
                if (old_reg.count != scbr_pkg::IMMORTAL)
                begin
                    d_we = 1'b1;
                    d_wdata = old_reg;
                    d_wdata.count = old_reg.count - 16'd1;
                    if (old_reg.count == 16'd1)
                    begin
                        l_we = 1'b1;
                        l_wdata = {head_vld_reg[old_reg.cls], head_idx_reg[old_reg.cls]};
                        push_now = 1'b1;
                        rsp_next.released = 1'b1;
                    end
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                rsp_next.pool_bytes_used = top_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            used_reg     <= '0;
            top_reg      <= '0;
            head_vld_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            top_reg   <= top_next;
            done_reg  <= state_reg == S_OUT;
            if (pop_now)
            begin
                head_vld_reg[qi] <= l_rdata[10];
            end
            if (push_now)
            begin
                head_vld_reg[push_q] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg <= cmd;
            realloc_reg <= 1'b0;
        end
        if (state_reg == S_RD)
        begin
            q_reg <= q_calc;
        end
        if (state_reg == S_CHK)
        begin
            old_reg <= d_rdata;
            realloc_reg <= cmd_reg.mode == scbr_pkg::MODE_REALLOC;
        end
        if (state_reg == S_ALLOC)
        begin
            new_reg <= head_idx_reg[qi];
        end
        if (pop_now)
        begin
            head_idx_reg[qi] <= l_rdata[9:0];
        end
        if (push_now)
        begin
            head_idx_reg[push_q] <= cmd_reg.handle;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the size-class buffer recycler. A predictor tracks
// free lists, reference counts and the bump pool; every result word is
// checked field by field against the oldest predicted word. Stimulus is a
// directed pass, random traffic and exhaustion.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT = 300000;
    localparam longint POOL_SIZE = 64'd1 << scbr_pkg::POOL_ADDR_BITS;

    class alloc_scoreboard;
        logic [10:0] head [scbr_pkg::NUM_CLASSES];
        logic [10:0] nxt [scbr_pkg::NUM_DESCRIPTORS];
        int unsigned refcnt [scbr_pkg::NUM_DESCRIPTORS];
        int unsigned bclass [scbr_pkg::NUM_DESCRIPTORS];
        longint base [scbr_pkg::NUM_DESCRIPTORS];
        int unsigned used;
        longint top;
        scbr_pkg::rsp_t pending [$];
        int errors;
        int checked;

        function new();
            foreach (head[i]) head[i] = '0;
            foreach (refcnt[i]) refcnt[i] = 0;
            used = 0;
            top = 0;
            errors = 0;
            checked = 0;
        endfunction

        function int unsigned class_for(logic [15:0] len);
            int unsigned l;
            int unsigned q;
            l = (int'(len) + 15) >> 4;
            q = 4;
            while (l > 0)
            begin
                q++;
                l >>= 1;
            end
            return q;
        endfunction

        function bit carve(logic [15:0] len, output int unsigned n);
            int unsigned q;
            longint sz;
            q = class_for(len);
            n = 0;
            if (head[q][10])
            begin
                n = head[q][9:0];
                head[q] = nxt[n];
            end
            else
            begin
                sz = 64'd1 << q;
                if (used >= scbr_pkg::NUM_DESCRIPTORS || top + sz > POOL_SIZE)
                begin
                    return 1'b1;
                end
                n = used;
                used++;
                base[n] = top;
                top += sz;
            end
            bclass[n] = q;
            refcnt[n] = 1;
            return 1'b0;
        endfunction

        function bit drop(int unsigned h);
            if (refcnt[h] == scbr_pkg::IMMORTAL)
            begin
                return 1'b0;
            end
            refcnt[h]--;
            if (refcnt[h] != 0)
            begin
                return 1'b0;
            end
            nxt[h] = head[bclass[h]];
            head[bclass[h]] = {1'b1, 10'(h)};
            return 1'b1;
        endfunction

        function void describe(int unsigned h, ref scbr_pkg::rsp_t r);
            r.result_handle = 10'(h);
            r.data_address = 24'(base[h] + 16);
            r.usable_bytes = 17'((64'd1 << bclass[h]) - 16);
            r.size_class = 5'(bclass[h]);
        endfunction

        function void note(scbr_pkg::cmd_t c);
            scbr_pkg::rsp_t r;
            int unsigned n;
            int unsigned h;
            longint fit;
            r = '0;
            h = c.handle;
            if (c.mode == scbr_pkg::MODE_ALLOC)
            begin
                if (carve(c.length, n)) r.status = scbr_pkg::ST_EXHAUST;
                else describe(n, r);
            end
            else if (h >= used || refcnt[h] == 0)
            begin
                r.status = scbr_pkg::ST_BAD;
            end
            else if (c.mode == scbr_pkg::MODE_FREE)
            begin
                describe(h, r);
                r.released = drop(h);
            end
            else if (c.mode == scbr_pkg::MODE_KEEP)
            begin
                if (refcnt[h] != scbr_pkg::IMMORTAL) refcnt[h]++;
                describe(h, r);
            end
            else
            begin
                fit = (64'd1 << bclass[h]) - 16;
                if (c.length <= fit)
                begin
                    describe(h, r);
                end
                else if (carve(c.length, n))
                begin
                    r.status = scbr_pkg::ST_EXHAUST;
                end
                else
                begin
                    describe(n, r);
                    r.copy_needed = 1'b1;
                    r.released = drop(h);
                end
            end
            r.pool_bytes_used = 25'(top);
            pending.push_back(r);
        endfunction

        function void field(string name, longint e, longint a);
            if (e != a)
            begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check(scbr_pkg::rsp_t a);
            scbr_pkg::rsp_t e;
            if (pending.size() == 0)
            begin
                $error("result word with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            field("result_handle", e.result_handle, a.result_handle);
            field("data_address", e.data_address, a.data_address);
            field("usable_bytes", e.usable_bytes, a.usable_bytes);
            field("size_class", e.size_class, a.size_class);
            field("released", e.released, a.released);
            field("copy_needed", e.copy_needed, a.copy_needed);
            field("status", e.status, a.status);
            field("pool_bytes_used", e.pool_bytes_used, a.pool_bytes_used);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    scbr_pkg::cmd_t cmd;
    logic busy;
    logic done;
    scbr_pkg::rsp_t rsp;
    int cycles;
    alloc_scoreboard sb;

    size_class_buffer_recycler_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (rst_n && done) sb.check(rsp);
    end

    function int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(logic [1:0] m, logic [15:0] len, logic [9:0] h, int gap);
        scbr_pkg::cmd_t c;
        c.mode = m;
        c.length = len;
        c.handle = h;
        start <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (busy);
        sb.note(c);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random();
        int p;
        logic [1:0] m;
        logic [15:0] len;
        logic [9:0] h;
        p = $urandom_range(0, 99);
        if (p < 35) m = scbr_pkg::MODE_ALLOC;
        else if (p < 65) m = scbr_pkg::MODE_FREE;
        else if (p < 80) m = scbr_pkg::MODE_KEEP;
        else m = scbr_pkg::MODE_REALLOC;
        if ($urandom_range(0, 9) == 0) len = 16'($urandom);
        else len = 16'($urandom_range(0, 300));
        if ($urandom_range(0, 9) < 8 && sb.used > 0) h = 10'($urandom_range(0, sb.used - 1));
        else h = 10'($urandom_range(0, 1023));
        send(m, len, h, pick_gap());
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(scbr_pkg::MODE_ALLOC, 16'd0, 10'd0, 0);
        send(scbr_pkg::MODE_ALLOC, 16'd1, 10'd0, 0);
        send(scbr_pkg::MODE_ALLOC, 16'd16, 10'd0, 2);
        send(scbr_pkg::MODE_ALLOC, 16'd17, 10'd0, 0);
        send(scbr_pkg::MODE_ALLOC, 16'hFFFF, 10'd0, 0);
        send(scbr_pkg::MODE_KEEP, 16'd0, 10'd0, 0);
        send(scbr_pkg::MODE_FREE, 16'd0, 10'd0, 1);
        send(scbr_pkg::MODE_FREE, 16'd0, 10'd0, 0);
        send(scbr_pkg::MODE_FREE, 16'd0, 10'd0, 0);
        send(scbr_pkg::MODE_KEEP, 16'd0, 10'h3FF, 0);
        send(scbr_pkg::MODE_REALLOC, 16'd0, 10'd900, 0);
        send(scbr_pkg::MODE_ALLOC, 16'd0, 10'd0, 5);
        send(scbr_pkg::MODE_REALLOC, 16'd10, 10'd1, 0);
        send(scbr_pkg::MODE_REALLOC, 16'd5000, 10'd1, 0);
        send(scbr_pkg::MODE_KEEP, 16'd0, 10'd3, 0);
        send(scbr_pkg::MODE_REALLOC, 16'hFFFF, 10'd3, 0);
        send(scbr_pkg::MODE_REALLOC, 16'hFFF0, 10'd2, 0);
        send(scbr_pkg::MODE_ALLOC, 16'd17, 10'd0, 0);

        repeat (100) send_random();

        while (sb.used < scbr_pkg::NUM_DESCRIPTORS && sb.top + (64'd1 << 17) <= POOL_SIZE)
            send(scbr_pkg::MODE_ALLOC, 16'hFFFF, 10'd0, pick_gap());
        send(scbr_pkg::MODE_ALLOC, 16'hFFFF, 10'd0, 0);
        while (sb.used < scbr_pkg::NUM_DESCRIPTORS && sb.top + 32 <= POOL_SIZE)
            send(scbr_pkg::MODE_ALLOC, 16'd0, 10'd0, pick_gap());
        send(scbr_pkg::MODE_ALLOC, 16'd0, 10'd0, 0);
        send(scbr_pkg::MODE_REALLOC, 16'hFFFF, 10'd1, 0);
        send(scbr_pkg::MODE_ALLOC, 16'h8000, 10'd0, 0);
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Checked %0d result words: directed, random traffic,", sb.checked);
        $display("and pool and descriptor exhaustion; %0d mismatches.", sb.errors);
        if (sb.errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
